// ===== design/svhs_pkg.sv =====
package svhs_pkg;

    // Signed working word for fractions and rates, all brought to a Q.48 scale.
    typedef logic signed [63:0] t_q;

    localparam t_q ONE_Q48 = 64'sh0001_0000_0000_0000;
    localparam t_q SAT_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

    // Operand and destination locations: codes below 32 are scratch memory
    // addresses, codes from 32 up name state registers and derived constants.
    typedef logic [5:0] t_loc;

    localparam t_loc L_BETA = 6'd0;
    localparam t_loc L_G    = 6'd1;
    localparam t_loc L_DR   = 6'd2;
    localparam t_loc L_BI   = 6'd3;
    localparam t_loc L_T    = 6'd4;
    localparam t_loc L_W    = 6'd5;
    localparam t_loc L_INF  = 6'd6;
    localparam t_loc L_FS   = 6'd7;
    localparam t_loc L_FI   = 6'd8;
    localparam t_loc L_FV   = 6'd9;
    localparam t_loc L_FR   = 6'd10;
    localparam t_loc L_FD   = 6'd11;
    localparam t_loc L_FN   = 6'd12;
    localparam t_loc L_KS   = 6'd13;
    localparam t_loc L_KI   = 6'd14;
    localparam t_loc L_KV   = 6'd15;
    localparam t_loc L_T2   = 6'd16;
    localparam t_loc L_XS   = 6'd32;
    localparam t_loc L_XI   = 6'd33;
    localparam t_loc L_XV   = 6'd34;
    localparam t_loc L_XR   = 6'd35;
    localparam t_loc L_XD   = 6'd36;
    localparam t_loc L_XN   = 6'd37;
    localparam t_loc L_RN   = 6'd38;
    localparam t_loc L_INVT = 6'd39;
    localparam t_loc L_DTH  = 6'd40;
    localparam t_loc L_GIN  = 6'd41;
    localparam t_loc L_RR   = 6'd42;
    localparam t_loc L_U    = 6'd43;
    localparam t_loc L_VR   = 6'd44;
    localparam t_loc L_TS   = 6'd45;

    typedef enum logic [1:0] {SH_12, SH_16, SH_48, SH_49} t_shift;
    typedef enum logic {OP_ADD, OP_MUL} t_opk;

    typedef struct packed {
        t_opk   op;
        t_loc   a;
        logic   na;
        t_loc   b;
        logic   nb;
        t_shift sh;
        t_loc   dst;
    } t_uop;

    typedef logic [5:0] t_pc;
    localparam t_pc PROG_LAST = 6'd52;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_INVT   = 3'd0;
    localparam t_cfg_idx CFG_DTH    = 3'd1;
    localparam t_cfg_idx CFG_VRATE  = 3'd2;
    localparam t_cfg_idx CFG_EFF    = 3'd3;
    localparam t_cfg_idx CFG_TS     = 3'd4;
    localparam t_cfg_idx CFG_INIT_I = 3'd5;
    localparam t_cfg_idx CFG_INIT_V = 3'd6;

    typedef struct packed {
        logic        action;
        logic [32:0] reproduction_number;
        logic        start_vaccination;
    } t_in;

    typedef struct packed {
        logic [48:0] susceptible;
        logic [48:0] infectious;
        logic [48:0] recovered;
        logic [48:0] deceased;
        logic [48:0] vaccinated;
        logic [48:0] ever_infected;
        logic        vaccinating;
    } t_out;

    function automatic t_q clamp01(input t_q x);
        t_q r;
        r = x;
        if (x < 0) begin
            r = '0;
        end else if (x > ONE_Q48) begin
            r = ONE_Q48;
        end
        return r;
    endfunction

    function automatic t_uop mk_mul(input t_loc a, input t_loc b, input t_shift sh,
                                    input t_loc dst);
        t_uop u;
        u.op = OP_MUL;
        u.a = a;
        u.na = 1'b0;
        u.b = b;
        u.nb = 1'b0;
        u.sh = sh;
        u.dst = dst;
        return u;
    endfunction

    function automatic t_uop mk_add(input t_loc a, input logic na, input t_loc b,
                                    input logic nb, input t_loc dst);
        t_uop u;
        u.op = OP_ADD;
        u.a = a;
        u.na = na;
        u.b = b;
        u.nb = nb;
        u.sh = SH_48;
        u.dst = dst;
        return u;
    endfunction

    // Step program: rate products, predictor derivative, predictor state,
    // corrector derivative summed onto the first one, then the state update.
    function automatic t_uop prog(input t_pc pc);
        t_uop u;
        case (pc)
            6'd0:  u = mk_mul(L_RN, L_INVT, SH_12, L_BETA);
            6'd1:  u = mk_mul(L_GIN, L_INVT, SH_16, L_G);
            6'd2:  u = mk_mul(L_DTH, L_INVT, SH_16, L_DR);
            6'd3:  u = mk_mul(L_BETA, L_XI, SH_48, L_BI);
            6'd4:  u = mk_mul(L_U, L_XV, SH_48, L_T);
            6'd5:  u = mk_add(L_XS, 1'b0, L_T, 1'b0, L_W);
            6'd6:  u = mk_mul(L_BI, L_W, SH_48, L_FN);
            6'd7:  u = mk_mul(L_BI, L_XS, SH_48, L_T);
            6'd8:  u = mk_add(L_T, 1'b1, L_VR, 1'b1, L_FS);
            6'd9:  u = mk_mul(L_G, L_XI, SH_48, L_T);
            6'd10: u = mk_add(L_FN, 1'b0, L_T, 1'b1, L_FI);
            6'd11: u = mk_mul(L_RR, L_XI, SH_48, L_FR);
            6'd12: u = mk_mul(L_DR, L_XI, SH_48, L_FD);
            6'd13: u = mk_mul(L_BI, L_U, SH_48, L_T);
            6'd14: u = mk_mul(L_T, L_XV, SH_48, L_T);
            6'd15: u = mk_add(L_VR, 1'b0, L_T, 1'b1, L_FV);
            6'd16: u = mk_mul(L_TS, L_FS, SH_48, L_T);
            6'd17: u = mk_add(L_XS, 1'b0, L_T, 1'b0, L_KS);
            6'd18: u = mk_mul(L_TS, L_FI, SH_48, L_T);
            6'd19: u = mk_add(L_XI, 1'b0, L_T, 1'b0, L_KI);
            6'd20: u = mk_mul(L_TS, L_FV, SH_48, L_T);
            6'd21: u = mk_add(L_XV, 1'b0, L_T, 1'b0, L_KV);
            6'd22: u = mk_mul(L_BETA, L_KI, SH_48, L_BI);
            6'd23: u = mk_mul(L_U, L_KV, SH_48, L_T);
            6'd24: u = mk_add(L_KS, 1'b0, L_T, 1'b0, L_W);
            6'd25: u = mk_mul(L_BI, L_W, SH_48, L_INF);
            6'd26: u = mk_add(L_FN, 1'b0, L_INF, 1'b0, L_FN);
            6'd27: u = mk_mul(L_BI, L_KS, SH_48, L_T);
            6'd28: u = mk_add(L_T, 1'b1, L_VR, 1'b1, L_T2);
            6'd29: u = mk_add(L_FS, 1'b0, L_T2, 1'b0, L_FS);
            6'd30: u = mk_mul(L_G, L_KI, SH_48, L_T);
            6'd31: u = mk_add(L_INF, 1'b0, L_T, 1'b1, L_T2);
            6'd32: u = mk_add(L_FI, 1'b0, L_T2, 1'b0, L_FI);
            6'd33: u = mk_mul(L_RR, L_KI, SH_48, L_T);
            6'd34: u = mk_add(L_FR, 1'b0, L_T, 1'b0, L_FR);
            6'd35: u = mk_mul(L_DR, L_KI, SH_48, L_T);
            6'd36: u = mk_add(L_FD, 1'b0, L_T, 1'b0, L_FD);
            6'd37: u = mk_mul(L_BI, L_U, SH_48, L_T);
            6'd38: u = mk_mul(L_T, L_KV, SH_48, L_T);
            6'd39: u = mk_add(L_VR, 1'b0, L_T, 1'b1, L_T2);
            6'd40: u = mk_add(L_FV, 1'b0, L_T2, 1'b0, L_FV);
            6'd41: u = mk_mul(L_TS, L_FS, SH_49, L_T);
            6'd42: u = mk_add(L_XS, 1'b0, L_T, 1'b0, L_XS);
            6'd43: u = mk_mul(L_TS, L_FI, SH_49, L_T);
            6'd44: u = mk_add(L_XI, 1'b0, L_T, 1'b0, L_XI);
            6'd45: u = mk_mul(L_TS, L_FV, SH_49, L_T);
            6'd46: u = mk_add(L_XV, 1'b0, L_T, 1'b0, L_XV);
            6'd47: u = mk_mul(L_TS, L_FR, SH_49, L_T);
            6'd48: u = mk_add(L_XR, 1'b0, L_T, 1'b0, L_XR);
            6'd49: u = mk_mul(L_TS, L_FD, SH_49, L_T);
            6'd50: u = mk_add(L_XD, 1'b0, L_T, 1'b0, L_XD);
            6'd51: u = mk_mul(L_TS, L_FN, SH_49, L_T);
            6'd52: u = mk_add(L_XN, 1'b0, L_T, 1'b0, L_XN);
            default: u = mk_add(L_T, 1'b0, L_T, 1'b0, L_T);
        endcase
        return u;
    endfunction

endpackage

// ===== design/svhs_mulq.sv =====
module svhs_mulq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  svhs_pkg::t_q    i_a,
    input  svhs_pkg::t_q    i_b,
    input  svhs_pkg::t_shift i_sh,
    output logic            o_done,
    output svhs_pkg::t_q    o_res
);
    import svhs_pkg::*;

    localparam logic [2:0] PH_LAST_PROD = 3'd3;
    localparam logic [2:0] PH_ACC       = 3'd4;
    localparam logic [2:0] PH_FIN       = 3'd5;

    logic         r_busy;
    logic [2:0]   r_ph;
    logic         r_done;
    logic         r_neg;
    logic [62:0]  r_ma;
    logic [62:0]  r_mb;
    t_shift       r_sh;
    logic [63:0]  r_prod;
    logic [1:0]   r_poff;
    logic [127:0] r_acc;
    t_q           r_res;

    logic [1:0]   k;
    logic [31:0]  ah;
    logic [31:0]  bh;
    logic [63:0]  prod;
    logic [1:0]   off;
    logic [127:0] acc_add;
    logic [127:0] shifted;
    logic [61:0]  mag;
    t_q           a_abs;
    t_q           b_abs;

    assign k       = r_ph[1:0];
    assign ah      = k[1] ? {1'b0, r_ma[62:32]} : r_ma[31:0];
    assign bh      = k[0] ? {1'b0, r_mb[62:32]} : r_mb[31:0];
    assign prod    = ah * bh;
    assign off     = {1'b0, k[1]} + {1'b0, k[0]};
    assign acc_add = {64'd0, r_prod} << {r_poff, 5'd0};
    assign a_abs   = i_a[63] ? -i_a : i_a;
    assign b_abs   = i_b[63] ? -i_b : i_b;

    always_comb begin
        case (r_sh)
            SH_12:   shifted = r_acc >> 12;
            SH_16:   shifted = r_acc >> 16;
            SH_48:   shifted = r_acc >> 48;
            SH_49:   shifted = r_acc >> 49;
            default: shifted = r_acc >> 48;
        endcase
        // Anything at or above 2^62 saturates to the symmetric limit.
        mag = (shifted[127:62] != '0) ? SAT_LIM[61:0] : shifted[61:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_ph == PH_FIN);
            if (i_start) begin
                r_busy <= 1'b1;
                r_ph   <= '0;
            end else if (r_busy) begin
                r_ph <= r_ph + 3'd1;
                if (r_ph == PH_FIN) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_a[63] ^ i_b[63];
            r_ma  <= a_abs[62:0];
            r_mb  <= b_abs[62:0];
            r_sh  <= i_sh;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_ph <= PH_LAST_PROD) begin
                r_prod <= prod;
                r_poff <= off;
            end
            if ((r_ph != 3'd0) && (r_ph <= PH_ACC)) begin
                r_acc <= r_acc + acc_add;
            end
            if (r_ph == PH_FIN) begin
                r_res <= r_neg ? -t_q'({2'b00, mag}) : t_q'({2'b00, mag});
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== design/sird_vaccination_heun_step_unit.sv =====
// SIRD epidemic step with vaccination, one Heun integration step per advance item.
//
// Input channel (i_in_valid / o_in_stall / i_in): an item is taken at a clock
// edge with valid high and stall low. action 0 advances the model one step
// with the given reproduction number; action 1 reloads the initial fractions.
// Output channel (o_out_valid / i_out_stall / o_out): one result item per input
// item, held in an output register until the receiver takes it. The block
// holds o_in_stall high while an item is being worked on.
// Configuration channel (i_cfg_valid / o_cfg_ready): always ready; registers
// should only be written while no item is in flight.
//
// A restart goes from the load state straight to the output state.
// An advance runs a 53-entry micro-program on one shared multiplier that needs
// 4 partial 32x32 products per multiply: 30 multiplies and 23 adds, plus
// load, clamp and output steps; no new item is taken until its result has
// been registered and the block is back in idle.
// If the receiver stalls, the next item is still taken and worked on; its
// result waits until the previous one has been handed over.
// Reset (i_rst_n low, synchronous) loads all configuration registers with
// their defaults, sets susceptible to one and the other fractions to zero.
module sird_vaccination_heun_step_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  svhs_pkg::t_in    i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output svhs_pkg::t_out   o_out,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  svhs_pkg::t_cfg_idx i_cfg_index,
    input  logic [48:0]      i_cfg_data
);
    import svhs_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_EXEC  = 7'b0001000,
        ST_WAIT  = 7'b0010000,
        ST_CLAMP = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    t_state      r_state;
    t_pc         r_pc;
    logic [32:0] r_invt;
    logic [32:0] r_dth;
    logic [32:0] r_vrate;
    logic [16:0] r_eff;
    logic [48:0] r_ts;
    logic [48:0] r_i0;
    logic [48:0] r_v0;
    logic [32:0] r_rn;
    logic        r_start;
    logic        r_restart;
    logic        r_act;
    t_q          r_s;
    t_q          r_i;
    t_q          r_v;
    t_q          r_r;
    t_q          r_d;
    t_q          r_n;
    t_q          r_rda;
    t_q          r_rdb;
    t_q          r_mem [32];
    logic        r_ovalid;
    t_out        r_out;

    t_uop        uop;
    t_q          a_val;
    t_q          b_val;
    t_q          a_eff;
    t_q          b_eff;
    logic signed [64:0] sum;
    t_q          sum_sat;
    logic        mul_start;
    logic        mul_done;
    t_q          mul_res;
    logic        wr_en;
    t_q          wr_val;
    logic        in_acc;
    logic        out_free;
    logic [16:0] eff_sat;
    t_q          gin;
    t_q          rr;
    t_q          u_val;
    t_q          vr;
    t_q          i0q;
    t_q          v0q;
    t_q          s0q;

    assign uop      = prog(r_pc);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_ovalid || !i_out_stall;

    assign eff_sat = (r_eff > 17'd65536) ? 17'd65536 : r_eff;
    assign gin     = $signed({31'd0, r_dth}) + 64'sh0000_0001_0000_0000;
    assign rr      = $signed({15'd0, r_invt, 16'd0});
    assign u_val   = $signed({15'd0, 17'd65536 - eff_sat, 32'd0});
    assign vr      = r_act ? $signed({15'd0, r_vrate, 16'd0}) : '0;
    assign i0q     = clamp01($signed({15'd0, r_i0}));
    assign v0q     = clamp01($signed({15'd0, r_v0}));
    assign s0q     = clamp01(ONE_Q48 - i0q - v0q);

    always_comb begin
        case (uop.a)
            L_XS:    a_val = r_s;
            L_XI:    a_val = r_i;
            L_XV:    a_val = r_v;
            L_XR:    a_val = r_r;
            L_XD:    a_val = r_d;
            L_XN:    a_val = r_n;
            L_RN:    a_val = $signed({31'd0, r_rn});
            L_INVT:  a_val = $signed({31'd0, r_invt});
            L_DTH:   a_val = $signed({31'd0, r_dth});
            L_GIN:   a_val = gin;
            L_RR:    a_val = rr;
            L_U:     a_val = u_val;
            L_VR:    a_val = vr;
            L_TS:    a_val = $signed({15'd0, r_ts});
            default: a_val = r_rda;
        endcase
        case (uop.b)
            L_XS:    b_val = r_s;
            L_XI:    b_val = r_i;
            L_XV:    b_val = r_v;
            L_XR:    b_val = r_r;
            L_XD:    b_val = r_d;
            L_XN:    b_val = r_n;
            L_RN:    b_val = $signed({31'd0, r_rn});
            L_INVT:  b_val = $signed({31'd0, r_invt});
            L_DTH:   b_val = $signed({31'd0, r_dth});
            L_GIN:   b_val = gin;
            L_RR:    b_val = rr;
            L_U:     b_val = u_val;
            L_VR:    b_val = vr;
            L_TS:    b_val = $signed({15'd0, r_ts});
            default: b_val = r_rdb;
        endcase
    end

    assign a_eff = uop.na ? -a_val : a_val;
    assign b_eff = uop.nb ? -b_val : b_val;
    assign sum   = $signed({a_eff[63], a_eff}) + $signed({b_eff[63], b_eff});

    always_comb begin
        if (sum > $signed({SAT_LIM[63], SAT_LIM})) begin
            sum_sat = SAT_LIM;
        end else if (sum < -$signed({SAT_LIM[63], SAT_LIM})) begin
            sum_sat = -SAT_LIM;
        end else begin
            sum_sat = sum[63:0];
        end
    end

    assign mul_start = (r_state == ST_EXEC) && (uop.op == OP_MUL);
    assign wr_en     = ((r_state == ST_EXEC) && (uop.op == OP_ADD))
                     || ((r_state == ST_WAIT) && mul_done);
    assign wr_val    = (r_state == ST_EXEC) ? sum_sat : mul_res;

    svhs_mulq u_mulq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (a_val),
        .i_b     (b_val),
        .i_sh    (uop.sh),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    // Scratch memory: two registered read ports, one write port.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_rda <= r_mem[uop.a[4:0]];
            r_rdb <= r_mem[uop.b[4:0]];
        end
        if (wr_en && !uop.dst[5]) begin
            r_mem[uop.dst[4:0]] <= wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rn      <= i_in.reproduction_number;
            r_start   <= i_in.start_vaccination;
            r_restart <= i_in.action;
        end
        if ((r_state == ST_OUT) && out_free) begin
            r_out.susceptible   <= r_s[48:0];
            r_out.infectious    <= r_i[48:0];
            r_out.recovered     <= r_r[48:0];
            r_out.deceased      <= r_d[48:0];
            r_out.vaccinated    <= r_v[48:0];
            r_out.ever_infected <= r_n[48:0];
            r_out.vaccinating   <= r_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invt  <= 33'd429496730;
            r_dth   <= 33'd8589935;
            r_vrate <= '0;
            r_eff   <= 17'd58982;
            r_ts    <= 49'd2814749767;
            r_i0    <= 49'd3391265;
            r_v0    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_INVT:   r_invt  <= i_cfg_data[32:0];
                CFG_DTH:    r_dth   <= i_cfg_data[32:0];
                CFG_VRATE:  r_vrate <= i_cfg_data[32:0];
                CFG_EFF:    r_eff   <= i_cfg_data[16:0];
                CFG_TS:     r_ts    <= i_cfg_data;
                CFG_INIT_I: r_i0    <= i_cfg_data;
                CFG_INIT_V: r_v0    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pc     <= '0;
            r_act    <= 1'b0;
            r_s      <= ONE_Q48;
            r_i      <= '0;
            r_v      <= '0;
            r_r      <= '0;
            r_d      <= '0;
            r_n      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if ((r_state == ST_OUT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (wr_en) begin
                case (uop.dst)
                    L_XS:    r_s <= wr_val;
                    L_XI:    r_i <= wr_val;
                    L_XV:    r_v <= wr_val;
                    L_XR:    r_r <= wr_val;
                    L_XD:    r_d <= wr_val;
                    L_XN:    r_n <= wr_val;
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (r_restart) begin
                        r_i     <= i0q;
                        r_v     <= v0q;
                        r_s     <= s0q;
                        r_r     <= '0;
                        r_d     <= '0;
                        r_n     <= '0;
                        r_act   <= r_start && (s0q > 0);
                        r_state <= ST_OUT;
                    end else begin
                        if (r_start && (r_s > 0)) begin
                            r_act <= 1'b1;
                        end
                        r_pc    <= '0;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_EXEC;
                end
                ST_EXEC: begin
                    if (uop.op == OP_MUL) begin
                        r_state <= ST_WAIT;
                    end else if (r_pc == PROG_LAST) begin
                        r_state <= ST_CLAMP;
                    end else begin
                        r_pc    <= r_pc + 6'd1;
                        r_state <= ST_READ;
                    end
                end
                ST_WAIT: begin
                    if (mul_done) begin
                        if (r_pc == PROG_LAST) begin
                            r_state <= ST_CLAMP;
                        end else begin
                            r_pc    <= r_pc + 6'd1;
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_CLAMP: begin
                    // Susceptible driven below zero ends the vaccination campaign.
                    if (r_s < 0) begin
                        r_act <= 1'b0;
                    end
                    r_s     <= clamp01(r_s);
                    r_i     <= clamp01(r_i);
                    r_v     <= clamp01(r_v);
                    r_r     <= clamp01(r_r);
                    r_d     <= clamp01(r_d);
                    r_n     <= clamp01(r_n);
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== design/svhs_checker.sv =====
module svhs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input svhs_pkg::t_out     o_out
);
    import svhs_pkg::*;

    // A held result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // An accepted item keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block took no time for an item");

    // Every reported fraction lies within zero and one.
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.susceptible <= ONE_Q48[48:0])
            && (o_out.infectious <= ONE_Q48[48:0])
            && (o_out.recovered <= ONE_Q48[48:0])
            && (o_out.deceased <= ONE_Q48[48:0])
            && (o_out.vaccinated <= ONE_Q48[48:0])
            && (o_out.ever_infected <= ONE_Q48[48:0]))
        else $error("fraction out of range");

    // No result appears right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

endmodule

bind sird_vaccination_heun_step_unit svhs_checker u_svhs_checker (.*);
